// ----- rtl/tkds_pkg.sv -----
// Shared constants, codes and types for the top-K dot-product selector.
// Depends on nothing; every other file but tkds_ram imports it.
`default_nettype none

package tkds_pkg;

  localparam int VECTOR_LENGTH  = 64;
  localparam int LIST_SIZE      = 64;
  localparam int MAX_CANDIDATES = 32768;

  localparam int OP_W   = 2;
  localparam int ELEM_W = 8;
  localparam int IDX_W  = 15;
  localparam int ACC_W  = 22;
  localparam int OUT_W  = 21;
  localparam int PROD_W = 2 * ELEM_W;

  localparam int POS_W = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
  localparam int RD_W  = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;

  localparam logic [OP_W-1:0] OP_TARGET = 2'd0;
  localparam logic [OP_W-1:0] OP_CAND   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'((1 << (ACC_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ~ACC_MAX;
  localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] OUT_MIN = ~OUT_MAX;

  typedef struct packed {
    logic                     valid;
    logic [IDX_W-1:0]         index;
    logic signed [ACC_W-1:0]  dot;
  } slot_t;

  // Command broadcast to every list cell.
  typedef struct packed {
    logic                     ins;
    logic                     clr;
    logic                     rot;
    logic [IDX_W-1:0]         idx;
    logic signed [ACC_W-1:0]  dot;
  } cell_cmd_t;

  // Element handed to the multiply-accumulate pipeline at acceptance.
  typedef struct packed {
    logic                     valid;
    logic                     is_cand;
    logic                     last;
    logic                     clr_list;
    logic [IDX_W-1:0]         idx;
    logic signed [ELEM_W-1:0] value;
    logic signed [ELEM_W-1:0] tgt;
  } mac_req_t;

endpackage

`default_nettype wire

// ----- rtl/tkds_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module tkds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/tkds_mac.sv -----
// Two-stage multiply-accumulate pipeline that turns vector elements into list commands.
// Depends on tkds_pkg.
`default_nettype none

module tkds_mac import tkds_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire mac_req_t  req,
  output cell_cmd_t      cmd,
  output logic           busy
);

  localparam logic signed [ACC_W:0] SUM_MAX = (ACC_W + 1)'(ACC_MAX);
  localparam logic signed [ACC_W:0] SUM_MIN = (ACC_W + 1)'(ACC_MIN);

  // Stage one: product register.
  logic                     s1_valid_r;
  logic                     s1_cand_r, s1_last_r, s1_clr_r;
  logic [IDX_W-1:0]         s1_idx_r;
  logic signed [PROD_W-1:0] s1_prod_r, s1_prod_nxt;

  // Stage two: accumulator and command register.
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     ins_r, ins_nxt, clr_r, clr_nxt;
  logic [IDX_W-1:0]         idx_r;
  logic signed [ACC_W-1:0]  dot_r, dot_nxt;
  logic signed [ACC_W:0]    sum;
  logic signed [ACC_W-1:0]  sum_sat;

  assign s1_prod_nxt = req.value * req.tgt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= req.valid;
    end
    s1_cand_r <= req.is_cand;
    s1_last_r <= req.last;
    s1_clr_r  <= req.clr_list;
    s1_idx_r  <= req.idx;
    s1_prod_r <= s1_prod_nxt;
  end

  always_comb begin
    sum = (ACC_W + 1)'(acc_r) + (ACC_W + 1)'(s1_prod_r);
    if (sum > SUM_MAX) begin
      sum_sat = ACC_MAX;
    end else if (sum < SUM_MIN) begin
      sum_sat = ACC_MIN;
    end else begin
      sum_sat = sum[ACC_W-1:0];
    end
    acc_nxt = acc_r;
    ins_nxt = 1'b0;
    clr_nxt = 1'b0;
    dot_nxt = sum_sat;
    if (s1_valid_r) begin
      if (s1_cand_r) begin
        acc_nxt = s1_last_r ? '0 : sum_sat;
        ins_nxt = s1_last_r &&
                  ((IDX_W + 17)'(s1_idx_r) < (IDX_W + 17)'(MAX_CANDIDATES));
      end else begin
        acc_nxt = '0;
        clr_nxt = s1_clr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      ins_r <= 1'b0;
      clr_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      ins_r <= ins_nxt;
      clr_r <= clr_nxt;
    end
    idx_r <= s1_idx_r;
    dot_r <= dot_nxt;
  end

  assign cmd  = '{ins: ins_r, clr: clr_r, rot: 1'b0, idx: idx_r, dot: dot_r};
  assign busy = s1_valid_r | ins_r | clr_r;

endmodule

`default_nettype wire

// ----- rtl/tkds_cell.sv -----
// One rank slot of the sorted list: compares a new entry and shifts from its neighbor.
// Depends on tkds_pkg.
`default_nettype none

module tkds_cell import tkds_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_cmd_t cmd,
  input  wire slot_t     prev_slot,
  input  wire logic      prev_beats,
  input  wire slot_t     next_slot,
  output slot_t          slot,
  output logic           beats
);

  slot_t slot_r, slot_nxt;

  // The new entry ranks above this slot, or the slot is empty.
  assign beats = cmd.ins && (!slot_r.valid || (cmd.dot > slot_r.dot) ||
                 ((cmd.dot == slot_r.dot) && (cmd.idx < slot_r.index)));

  // Rotation moves every entry one slot toward the head of the row.
  always_comb begin
    slot_nxt = slot_r;
    if (cmd.clr) begin
      slot_nxt.valid = 1'b0;
    end else if (cmd.rot) begin
      slot_nxt = next_slot;
    end else if (prev_beats) begin
      slot_nxt = prev_slot;
    end else if (beats) begin
      slot_nxt = '{valid: 1'b1, index: cmd.idx, dot: cmd.dot};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else begin
      slot_r.valid <= slot_nxt.valid;
    end
    slot_r.index <= slot_nxt.index;
    slot_r.dot   <= slot_nxt.dot;
  end

  assign slot = slot_r;

endmodule

`default_nettype wire

// ----- rtl/top_k_dot_product_selector.sv -----
// Top-K dot-product selector: target RAM, position counter, MAC pipeline, cell chain.
// Target and candidate items are accepted one per cycle outside readout; a candidate's
// insertion reaches the list through the two MAC stages, product and accumulator registers.
// A readout item stalls the input, waits for the MAC pipeline to drain, then delivers
// LIST_SIZE result items at one per cycle while out_ready is high, by rotating the row.
// Reset empties the list and clears position and accumulator; target RAM stays undefined.
`default_nettype none

module top_k_dot_product_selector import tkds_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [OP_W-1:0]          in_operation,
  input  wire logic signed [ELEM_W-1:0] in_element_value,
  input  wire logic                     in_element_last,
  input  wire logic [IDX_W-1:0]         in_candidate_index,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [IDX_W-1:0]              out_neighbor_index,
  output logic                          out_neighbor_valid,
  output logic signed [OUT_W-1:0]       out_neighbor_dot,
  output logic                          out_run_last
);

  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic             in_acc;
  logic             is_elem;
  logic             state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [RD_W-1:0]  rd_cnt_r, rd_cnt_nxt;
  logic             ram_we;
  logic signed [ELEM_W-1:0] ram_rdata;
  logic             byp_r;
  logic signed [ELEM_W-1:0] byp_data_r;
  logic signed [ELEM_W-1:0] tgt;
  logic             out_acc;
  logic             rd_done;
  logic             mac_busy;
  mac_req_t         mac_req;
  cell_cmd_t        mac_cmd, cmd;
  slot_t            slots [LIST_SIZE];
  logic             beats [LIST_SIZE];
  logic signed [ACC_W-1:0] dot_sat;

  // Input is taken only while no readout is in progress.
  assign in_ready = (state_r == ST_RUN);
  assign in_acc   = in_valid && in_ready;
  assign is_elem  = (in_operation == OP_TARGET) || (in_operation == OP_CAND);

  // Target and candidate elements share one position counter that wraps at the
  // vector length or returns to zero on the last element.
  always_comb begin
    pos_nxt = pos_r;
    if (in_acc && is_elem) begin
      if (in_element_last || (pos_r == POS_W'(VECTOR_LENGTH - 1))) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  assign ram_we = in_acc && (in_operation == OP_TARGET);

  // The RAM is always read at the next position, so its output register holds the
  // target element of the current position. When a write hits that same address the
  // written value is forwarded for one cycle.
  tkds_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (VECTOR_LENGTH)
  ) u_target_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r),
    .wdata (in_element_value),
    .raddr (pos_nxt),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= ram_we && (pos_nxt == pos_r);
    end
    byp_data_r <= in_element_value;
  end

  assign tgt = byp_r ? byp_data_r : ram_rdata;

  // A target element at position zero starts a new target and empties the list.
  assign mac_req = '{
    valid:    in_acc && is_elem,
    is_cand:  (in_operation == OP_CAND),
    last:     in_element_last,
    clr_list: (in_operation == OP_TARGET) && (pos_r == '0),
    idx:      in_candidate_index,
    value:    in_element_value,
    tgt:      tgt
  };

  tkds_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .cmd   (mac_cmd),
    .busy  (mac_busy)
  );

  // Readout: once the pipeline is empty, slot zero is shown; each delivered item
  // rotates the row by one, so after LIST_SIZE items the list is back in place.
  assign out_valid = (state_r == ST_READ) && !mac_busy;
  assign out_acc   = out_valid && out_ready;
  assign rd_done   = (rd_cnt_r == RD_W'(LIST_SIZE - 1));

  always_comb begin
    state_nxt  = state_r;
    rd_cnt_nxt = rd_cnt_r;
    case (state_r)
      ST_RUN: begin
        if (in_acc && (in_operation == OP_READ)) begin
          state_nxt  = ST_READ;
          rd_cnt_nxt = '0;
        end
      end
      ST_READ: begin
        if (out_acc) begin
          if (rd_done) begin
            state_nxt  = ST_RUN;
            rd_cnt_nxt = '0;
          end else begin
            rd_cnt_nxt = rd_cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_RUN;
      pos_r    <= '0;
      rd_cnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      rd_cnt_r <= rd_cnt_nxt;
    end
  end

  // Insert and clear come from the MAC; rotation comes from the readout.
  assign cmd = '{ins: mac_cmd.ins, clr: mac_cmd.clr, rot: out_acc,
                 idx: mac_cmd.idx, dot: mac_cmd.dot};

  // The cell row. Each cell takes its upper neighbor's entry when the new entry
  // ranks above that neighbor. For readout rotation each cell takes its lower
  // neighbor's entry and the last slot takes slot zero's, which closes the ring.
  for (genvar i = 0; i < LIST_SIZE; i++) begin : g_cell
    slot_t prev_slot;
    logic  prev_beats;
    slot_t next_slot;
    if (i == 0) begin : g_head
      assign prev_slot  = '0;
      assign prev_beats = 1'b0;
    end else begin : g_body
      assign prev_slot  = slots[i-1];
      assign prev_beats = beats[i-1];
    end
    if (i == LIST_SIZE - 1) begin : g_tail
      assign next_slot = slots[0];
    end else begin : g_inner
      assign next_slot = slots[i+1];
    end
    tkds_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .prev_slot  (prev_slot),
      .prev_beats (prev_beats),
      .next_slot  (next_slot),
      .slot       (slots[i]),
      .beats      (beats[i])
    );
  end

  // Result payload: slot zero, with the dot clamped to the output range and
  // empty slots shown as zeros.
  always_comb begin
    if (slots[0].dot > OUT_MAX) begin
      dot_sat = OUT_MAX;
    end else if (slots[0].dot < OUT_MIN) begin
      dot_sat = OUT_MIN;
    end else begin
      dot_sat = slots[0].dot;
    end
  end

  assign out_neighbor_valid = slots[0].valid;
  assign out_neighbor_index = slots[0].valid ? slots[0].index : '0;
  assign out_neighbor_dot   = slots[0].valid ? dot_sat[OUT_W-1:0] : '0;
  assign out_run_last       = rd_done;

  // Results are never offered while input items are being taken.
  a_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("result offered while input is open");

  // The row never rotates while an insert or clear is in flight.
  a_rot_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> !(mac_cmd.ins || mac_cmd.clr))
    else $error("rotation collided with a list update");

  // The final item of a readout reopens the input.
  a_read_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_run_last) |=> in_ready)
    else $error("input not reopened after readout");

  // A readout item starts the readout on the next cycle.
  a_read_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_operation == OP_READ)) |=> (!in_ready && (rd_cnt_r == '0)))
    else $error("readout did not start");

endmodule

`default_nettype wire

// ----- tb/tkds_checker.sv -----
// Scoreboard for the top-K dot-product selector: watches both channels, keeps its own
// copy of the target vector, running dot and ranked list, and compares every result item.
// Depends on tkds_pkg for widths, operation codes and saturation limits.

module tkds_checker import tkds_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [OP_W-1:0]          in_operation,
  input  logic signed [ELEM_W-1:0] in_element_value,
  input  logic                     in_element_last,
  input  logic [IDX_W-1:0]         in_candidate_index,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [IDX_W-1:0]         out_neighbor_index,
  input  logic                     out_neighbor_valid,
  input  logic signed [OUT_W-1:0]  out_neighbor_dot,
  input  logic                     out_run_last,
  output int                       fail_count,
  output int                       pending,
  output int                       result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [IDX_W-1:0]        index;
    logic                    valid;
    logic signed [OUT_W-1:0] dot;
    logic                    last;
  } neighbor_t;

  logic signed [ELEM_W-1:0] target_mem [VECTOR_LENGTH];
  int                       pos;
  int                       run_dot;
  logic                     rank_valid [LIST_SIZE];
  logic [IDX_W-1:0]         rank_index [LIST_SIZE];
  int                       rank_dot   [LIST_SIZE];
  neighbor_t                expected_neighbors [$];

  int fails   = 0;
  int waiting = 0;
  int checked = 0;

  assign fail_count   = fails;
  assign pending      = waiting;
  assign result_count = checked;

  function automatic int clamp(int v, int lo, int hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    fails++;
    if (fails <= 100) begin
      $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  task automatic clear_model();
    pos     = 0;
    run_dot = 0;
    foreach (target_mem[i]) target_mem[i] = '0;
    foreach (rank_valid[i]) begin
      rank_valid[i] = 1'b0;
      rank_index[i] = '0;
      rank_dot[i]   = 0;
    end
    expected_neighbors.delete();
  endtask

  task automatic step_position(logic last);
    if (last || pos + 1 >= VECTOR_LENGTH) pos = 0;
    else pos++;
  endtask

  // Larger dot ranks first; on equal dots the smaller index ranks first.
  task automatic rank_insert(logic [IDX_W-1:0] idx, int dot);
    int p;
    p = 0;
    while (p < LIST_SIZE && rank_valid[p]) begin
      if (dot > rank_dot[p] || (dot == rank_dot[p] && idx < rank_index[p])) break;
      p++;
    end
    if (p < LIST_SIZE) begin
      for (int j = LIST_SIZE - 1; j > p; j--) begin
        rank_valid[j] = rank_valid[j-1];
        rank_index[j] = rank_index[j-1];
        rank_dot[j]   = rank_dot[j-1];
      end
      rank_valid[p] = 1'b1;
      rank_index[p] = idx;
      rank_dot[p]   = dot;
    end
  endtask

  task automatic predict_readout();
    neighbor_t n;
    for (int k = 0; k < LIST_SIZE; k++) begin
      if (rank_valid[k]) begin
        n.index = rank_index[k];
        n.valid = 1'b1;
        n.dot   = OUT_W'(clamp(rank_dot[k], int'(OUT_MIN), int'(OUT_MAX)));
      end else begin
        n.index = '0;
        n.valid = 1'b0;
        n.dot   = '0;
      end
      n.last = (k == LIST_SIZE - 1);
      expected_neighbors.push_back(n);
    end
  endtask

  task automatic apply_item(logic [OP_W-1:0] op, logic signed [ELEM_W-1:0] value,
                            logic last, logic [IDX_W-1:0] idx);
    case (op)
      OP_TARGET: begin
        if (pos == 0) begin
          foreach (rank_valid[i]) rank_valid[i] = 1'b0;
        end
        run_dot = 0;
        target_mem[pos] = value;
        step_position(last);
      end
      OP_CAND: begin
        run_dot = clamp(run_dot + int'(value) * int'(target_mem[pos]),
                        int'(ACC_MIN), int'(ACC_MAX));
        if (last) begin
          if (int'(idx) < MAX_CANDIDATES) rank_insert(idx, run_dot);
          run_dot = 0;
        end
        step_position(last);
      end
      OP_READ: predict_readout();
      default: ;
    endcase
  endtask

  task automatic compare_result();
    neighbor_t exp_n;
    checked++;
    if (expected_neighbors.size() == 0) begin
      report_mismatch("result item with nothing expected (index)", -1,
                      int'(out_neighbor_index));
    end else begin
      exp_n = expected_neighbors.pop_front();
      if (out_neighbor_index !== exp_n.index)
        report_mismatch("neighbor_index", int'(exp_n.index), int'(out_neighbor_index));
      if (out_neighbor_valid !== exp_n.valid)
        report_mismatch("neighbor_valid", int'(exp_n.valid), int'(out_neighbor_valid));
      if (out_neighbor_dot !== exp_n.dot)
        report_mismatch("neighbor_dot", int'(exp_n.dot), int'(out_neighbor_dot));
      if (out_run_last !== exp_n.last)
        report_mismatch("run_last", int'(exp_n.last), int'(out_run_last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
    end else begin
      if (out_valid && out_ready) compare_result();
      if (in_valid && in_ready) begin
        apply_item(in_operation, in_element_value, in_element_last, in_candidate_index);
      end
    end
    waiting = expected_neighbors.size();
  end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the top-K dot-product selector: clock, reset, stimulus and verdict.
// Depends on tkds_pkg, the block itself and the tkds_checker scoreboard.

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tkds_pkg::*;

  // Operation code the block ignores; it has no name in the package.
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  localparam int RANDOM_ITEMS  = 20;
  localparam int LONG_HOLD     = 300;
  localparam int DRAIN_CYCLES  = 24;
  localparam int OVERFLOW_LEN  = 146;
  localparam int FILL_COUNT    = 66;
  localparam int TIME_LIMIT_NS = 25_000_000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid           = 1'b0;
  logic                     in_ready;
  logic [OP_W-1:0]          in_operation       = OP_NONE;
  logic signed [ELEM_W-1:0] in_element_value   = '0;
  logic                     in_element_last    = 1'b0;
  logic [IDX_W-1:0]         in_candidate_index = '0;
  logic                     out_valid;
  logic                     out_ready          = 1'b0;
  logic [IDX_W-1:0]         out_neighbor_index;
  logic                     out_neighbor_valid;
  logic signed [OUT_W-1:0]  out_neighbor_dot;
  logic                     out_run_last;

  int fail_count;
  int pending;
  int result_count;

  // Sender pacing: 0 means back to back, 1 means a random idle gap before every item,
  // 2 means mostly back to back with an occasional gap.
  int tx_mode          = 1;
  int items_sent       = 0;
  int useful_items     = 0;
  int readouts_sent    = 0;
  int holds_requested  = 0;
  int holds_granted    = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  top_k_dot_product_selector u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_element_value   (in_element_value),
    .in_element_last    (in_element_last),
    .in_candidate_index (in_candidate_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_neighbor_index (out_neighbor_index),
    .out_neighbor_valid (out_neighbor_valid),
    .out_neighbor_dot   (out_neighbor_dot),
    .out_run_last       (out_run_last)
  );

  tkds_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_element_value   (in_element_value),
    .in_element_last    (in_element_last),
    .in_candidate_index (in_candidate_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_neighbor_index (out_neighbor_index),
    .out_neighbor_valid (out_neighbor_valid),
    .out_neighbor_dot   (out_neighbor_dot),
    .out_run_last       (out_run_last),
    .fail_count         (fail_count),
    .pending            (pending),
    .result_count       (result_count)
  );

  function automatic int draw_gap(int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 16);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  // Values: mode 1 draws from a tiny palette so that dot products collide and the
  // tie-break on index gets exercised; mode 0 covers the whole byte with the
  // extremes weighted up.
  function automatic logic signed [ELEM_W-1:0] pick_value(int mode);
    if (mode == 1) return ELEM_W'($urandom_range(0, 3) - 1);
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 5))
        0:       return -8'sd128;
        1:       return 8'sd127;
        2:       return -8'sd127;
        3:       return 8'sd0;
        4:       return -8'sd1;
        default: return 8'sd1;
      endcase
    end
    return ELEM_W'($urandom_range(0, 255));
  endfunction

  // Indexes: a small pool for repeats and ties, the two ends, or anything.
  function automatic logic [IDX_W-1:0] pick_index();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return IDX_W'($urandom_range(0, 7));
    if (r == 3) return ($urandom_range(0, 1) != 0) ? {IDX_W{1'b1}} : '0;
    return IDX_W'($urandom_range(0, 32767));
  endfunction

  // Offers one item after the drawn number of idle cycles and holds it, unchanged,
  // until the block takes it. Valid is only lowered when a gap follows, so it never
  // sees a low and a high assignment in the same step.
  task automatic send_item(logic [OP_W-1:0] op, logic signed [ELEM_W-1:0] value,
                           logic last, logic [IDX_W-1:0] idx);
    int gap;
    gap = draw_gap(tx_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_operation       <= op;
    in_element_value   <= value;
    in_element_last    <= last;
    in_candidate_index <= idx;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (op != OP_NONE) useful_items++;
    if (op == OP_READ) readouts_sent++;
  endtask

  // One vector of len elements, element_last on the final one unless open is set.
  task automatic send_vector(logic [OP_W-1:0] op, int len, logic [IDX_W-1:0] idx,
                             int value_mode, bit open);
    for (int i = 0; i < len; i++) begin
      send_item(op, pick_value(value_mode), (i == len - 1) && !open, idx);
    end
  endtask

  // The sender goes quiet until every expected result item has come out. The
  // pending count is read on the falling edge, away from the checker's update.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Receiver: draws a stall before each result item, and serves a long hold-off
  // whenever the stimulus asks for one. A new pacing mode is drawn per readout.
  initial begin : receiver
    int gap;
    int rx_mode;
    rx_mode = 1;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (holds_granted < holds_requested) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_granted++;
      end else begin
        gap = draw_gap(rx_mode);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (out_run_last) rx_mode = $urandom_range(0, 2);
    end
  end

  initial begin : watchdog
    #(TIME_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int kind;
    int seq_count;
    int stop_at;
    logic signed [ELEM_W-1:0] sat_value;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Fill every target position before any candidate runs, so no candidate ever
    // meets an unwritten target element. element_last stays low throughout: the
    // position wraps from the top back to zero on its own. Positions from six
    // upward hold -128 so that a long candidate can drive the running dot to its top.
    for (int i = 0; i < VECTOR_LENGTH; i++) begin
      case (i)
        0:       sat_value = -8'sd128;
        1:       sat_value = 8'sd127;
        2:       sat_value = -8'sd127;
        3:       sat_value = 8'sd0;
        4:       sat_value = -8'sd1;
        5:       sat_value = 8'sd1;
        default: sat_value = -8'sd128;
      endcase
      send_item(OP_TARGET, sat_value, 1'b0, '0);
    end

    // Directed part. Targets at positions 0..2 are -128, 127 and -127.
    send_item(OP_READ, '0, 1'b0, '0);                   // readout of an empty list
    send_item(OP_CAND, 8'sd127, 1'b0, {IDX_W{1'b1}});  // top index, extreme values
    send_item(OP_CAND, -8'sd128, 1'b1, {IDX_W{1'b1}});
    send_item(OP_CAND, -8'sd128, 1'b1, '0);             // largest single product
    send_item(OP_CAND, 8'sd0, 1'b1, IDX_W'(5));         // equal dots: index 3 must
    send_item(OP_CAND, 8'sd0, 1'b1, IDX_W'(3));         // rank ahead of index 5
    send_item(OP_CAND, 8'sd0, 1'b1, IDX_W'(5));         // the same index again
    // An ignored operation in the middle of a vector must not move the position.
    send_item(OP_CAND, 8'sd1, 1'b0, IDX_W'(9));
    send_item(OP_NONE, -8'sd1, 1'b1, {IDX_W{1'b1}});
    send_item(OP_CAND, -8'sd1, 1'b1, IDX_W'(9));
    // A target element inside a candidate shares the position counter, rewrites
    // that target slot and clears the running dot, but leaves the list alone.
    send_item(OP_CAND, 8'sd2, 1'b0, IDX_W'(12));
    send_item(OP_TARGET, 8'sd127, 1'b0, '0);
    send_item(OP_CAND, -8'sd128, 1'b1, IDX_W'(12));
    send_item(OP_READ, '0, 1'b0, '0);
    // A target element at position zero empties the list.
    send_item(OP_TARGET, -8'sd128, 1'b1, '0);
    send_item(OP_READ, '0, 1'b0, '0);
    wait_results_done();

    // Accumulator saturation: a long candidate of -128 elements that wraps the
    // position twice runs past the top of the range, and its dot is clamped again
    // to the narrower output range on readout.
    for (int i = 0; i < OVERFLOW_LEN; i++) begin
      send_item(OP_CAND, -8'sd128, i == OVERFLOW_LEN - 1, pick_index());
    end
    send_item(OP_READ, '0, 1'b0, '0);

    // Overfill the list with single-element candidates: later entries push the
    // last slot out, and low dots against a full list are dropped.
    tx_mode = 2;
    for (int i = 0; i < FILL_COUNT; i++) begin
      send_item(OP_CAND, pick_value(0), 1'b1, pick_index());
    end
    send_item(OP_READ, '0, 1'b0, '0);

    // Back pressure: the receiver holds off for a long stretch while a readout
    // and more items are offered, so the block backs up into its input.
    tx_mode = 0;
    holds_requested++;
    send_item(OP_READ, '0, 1'b0, '0);
    for (int i = 0; i < 6; i++) send_item(OP_CAND, pick_value(1), 1'b1, pick_index());
    send_item(OP_READ, '0, 1'b0, '0);
    wait_results_done();

    // Random part: mostly well-formed vectors with random content, plus readouts,
    // noise, vectors left open and pauses that let the list drain.
    seq_count = 0;
    stop_at   = useful_items + RANDOM_ITEMS;
    while (useful_items < stop_at) begin
      if (seq_count % 8 == 0) tx_mode = $urandom_range(0, 2);
      if (seq_count == 4) begin
        holds_requested++;
        send_item(OP_READ, '0, 1'b0, '0);
      end
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        send_vector(OP_TARGET, ($urandom_range(0, 9) == 0) ? VECTOR_LENGTH
                                                          : $urandom_range(1, 8),
                    pick_index(), 0, 1'b0);
      end else if (kind < 60) begin
        send_vector(OP_CAND, ($urandom_range(0, 1) != 0) ? 1 : $urandom_range(2, 4),
                    pick_index(), ($urandom_range(0, 2) == 0) ? 1 : 0, 1'b0);
      end else if (kind < 72) begin
        send_item(OP_READ, pick_value(0), 1'($urandom_range(0, 1)), pick_index());
      end else if (kind < 80) begin
        send_item(OP_W'($urandom_range(0, 3)), ELEM_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), IDX_W'($urandom_range(0, 32767)));
      end else if (kind < 86) begin
        send_vector(OP_CAND, $urandom_range(1, 6), pick_index(), 0, 1'b1);
      end else if (kind < 92) begin
        send_item(OP_NONE, ELEM_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  IDX_W'($urandom_range(0, 32767)));
      end else begin
        wait_results_done();
      end
      seq_count++;
    end
    send_item(OP_READ, '0, 1'b0, '0);

    // End of run: everything expected must arrive, then a quiet stretch in which
    // no stray result item may appear.
    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("Run covered %0d items (%0d readouts) and %0d result items checked.",
             items_sent, readouts_sent, result_count);
    $display("Included saturation, list overfill, ties and %0d long output stalls.",
             holds_granted);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
